/* design/evnf_pkg.sv */
// shared widths, register indexes and fixed-point constants for the
// energy vad with noise floor; no dependencies
package evnf_pkg;

    localparam int ENERGY_W    = 24;
    localparam int COEF_W      = 15;
    localparam int IDX_W       = 8;
    localparam int FIELD_W     = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 80;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int Q15_SHIFT   = 15;

    localparam logic [ENERGY_W-1:0] MAX24    = 24'hFF_FFFF;
    localparam logic [COEF_W-1:0]   Q15_HALF = 15'd16384;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_BAND_START = 3'd0;
    localparam t_cfg_idx CFG_BAND_END   = 3'd1;
    localparam t_cfg_idx CFG_FAST_KEEP  = 3'd2;
    localparam t_cfg_idx CFG_FAST_GAIN  = 3'd3;
    localparam t_cfg_idx CFG_SLOW_KEEP  = 3'd4;
    localparam t_cfg_idx CFG_SLOW_GAIN  = 3'd5;
    localparam t_cfg_idx CFG_MARGIN     = 3'd6;
    localparam t_cfg_idx CFG_HANGOVER   = 3'd7;

endpackage

/* design/energy_vad_noise_floor.sv */
// energy voice activity detector with tracked noise floor and hangover
// depends on evnf_pkg; one shared multiply-accumulate unit under a sequencer
//
// channel   dir  signals                      word layout (lsb first)
// s_axis    in   tvalid tready tdata tlast    bin_real[15:0] bin_imag[31:16] bin_index[39:32]
// m_axis    out  tvalid tready tdata          voice_active[0] frame_energy[24:1]
//                                             smoothed_energy[48:25] noise_floor[72:49]
// cfg       in   i_cfg_we i_cfg_idx i_cfg_data  register index 0..7, no read-back
//
// an in-band bin runs two squares on the shared multiplier, then one square root
// digit per cycle for SAMPLE_BITS digits, then one accumulate
// an out-of-band bin is dropped as it is accepted; a frame end runs the two
// blends on the same multiplier, each with a rounding step, plus the result hand-off
// reset is synchronous, active low; config returns to its defaults, state to zero
// the result sits in an output register, so input keeps flowing while it waits;
// only a second frame end stalls in the hand-off cycle until the result is taken
module energy_vad_noise_floor #(
    parameter int BIN_COUNT   = 256,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // bin_real[15:0], bin_imag[31:16], bin_index[39:32]
    input  logic [evnf_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    input  logic                                 s_axis_tlast,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // voice_active[0], frame_energy[24:1], smoothed_energy[48:25], noise_floor[72:49]
    output logic [evnf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic                                 i_cfg_we,
    input  logic [evnf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [evnf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int EW  = evnf_pkg::ENERGY_W;
    localparam int CWC = evnf_pkg::COEF_W;
    localparam int SB  = SAMPLE_BITS;
    // raw field width seen by the sample mask
    localparam int RW  = (SB > evnf_pkg::FIELD_W) ? SB : evnf_pkg::FIELD_W;
    // multiplier operand width: samples or energies, whichever is wider
    localparam int MW  = (SB > EW) ? SB : EW;
    localparam int PW  = 2 * MW;
    // running sum width before saturation
    localparam int SW  = (SB > EW) ? SB + 1 : EW + 1;
    localparam int CNW = $clog2(SAMPLE_BITS);

    // sequencer codes
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SQ_A   = 4'd1;
    localparam logic [3:0] ST_SQ_B   = 4'd2;
    localparam logic [3:0] ST_ROOT   = 4'd3;
    localparam logic [3:0] ST_ACC    = 4'd4;
    localparam logic [3:0] ST_SM_A   = 4'd5;
    localparam logic [3:0] ST_SM_B   = 4'd6;
    localparam logic [3:0] ST_SM_RND = 4'd7;
    localparam logic [3:0] ST_FL_A   = 4'd8;
    localparam logic [3:0] ST_FL_B   = 4'd9;
    localparam logic [3:0] ST_FL_RND = 4'd10;
    localparam logic [3:0] ST_EMIT   = 4'd11;

    // config registers
    logic [evnf_pkg::IDX_W-1:0] r_band_start, r_band_end, r_hang_frames;
    logic [CWC-1:0]             r_fast_keep, r_fast_gain, r_slow_keep, r_slow_gain;
    logic [EW-1:0]              r_margin;

    // control state
    logic [3:0]     r_state, n_state;
    logic [CNW-1:0] r_cnt;
    logic           r_last;
    logic           r_slow;
    logic [7:0]     r_hold;
    logic           r_act;
    logic [EW-1:0]  r_sum, r_smooth, r_floor, r_en;
    logic           r_out_valid;

    // datapath payload
    logic [SB-1:0]  r_mag_a, r_mag_b;
    logic [PW-1:0]  r_acc;
    logic [SB-1:0]  r_root;
    logic [SB+1:0]  r_rem;
    logic           r_o_voice;
    logic [EW-1:0]  r_o_energy, r_o_smooth, r_o_floor;

    // input unpack
    logic [evnf_pkg::FIELD_W-1:0] in_real, in_imag;
    logic [evnf_pkg::IDX_W-1:0]   in_idx;
    logic [RW-1:0]                raw_re, raw_im;
    logic [SB-1:0]                v_re, v_im, mag_re, mag_im;
    logic                         in_band;
    logic                         in_acc;

    assign in_real = s_axis_tdata[15:0];
    assign in_imag = s_axis_tdata[31:16];
    assign in_idx  = s_axis_tdata[39:32];
    assign raw_re  = RW'(in_real);
    assign raw_im  = RW'(in_imag);
    assign v_re    = raw_re[SB-1:0];
    assign v_im    = raw_im[SB-1:0];
    // two's complement magnitude over the low sample bits
    assign mag_re  = v_re[SB-1] ? (~v_re + SB'(1)) : v_re;
    assign mag_im  = v_im[SB-1] ? (~v_im + SB'(1)) : v_im;
    assign in_band = (in_idx >= r_band_start) && (in_idx <= r_band_end)
                   && (32'(in_idx) < 32'(BIN_COUNT));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // shared multiplier operand select
    logic [MW-1:0] mul_a, mul_b;
    logic [PW-1:0] prod;
    logic [CWC-1:0] keep_sel, gain_sel;

    // slow coefficients while the floor sits below the smoothed energy
    assign keep_sel = r_slow ? r_slow_keep : r_fast_keep;
    assign gain_sel = r_slow ? r_slow_gain : r_fast_gain;

    always_comb begin
        unique case (r_state)
            ST_SQ_A: begin
                mul_a = MW'(r_mag_a);
                mul_b = MW'(r_mag_a);
            end
            ST_SQ_B: begin
                mul_a = MW'(r_mag_b);
                mul_b = MW'(r_mag_b);
            end
            ST_SM_A: begin
                mul_a = MW'(r_fast_keep);
                mul_b = MW'(r_smooth);
            end
            ST_SM_B: begin
                mul_a = MW'(r_fast_gain);
                mul_b = MW'(r_en);
            end
            ST_FL_A: begin
                mul_a = MW'(keep_sel);
                mul_b = MW'(r_floor);
            end
            ST_FL_B: begin
                mul_a = MW'(gain_sel);
                mul_b = MW'(r_en);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // q15 round half up and saturate at 24 bits
    logic [PW-1:0] rnd_full;
    logic [EW-1:0] rnd_sat;
    assign rnd_full = (r_acc + PW'(evnf_pkg::Q15_HALF)) >> evnf_pkg::Q15_SHIFT;
    assign rnd_sat  = (rnd_full > PW'(evnf_pkg::MAX24)) ? evnf_pkg::MAX24
                                                         : rnd_full[EW-1:0];

    // one restoring square root digit: bring down two bits, try 4q+1
    logic [SB+3:0] rem_sh, trial;
    logic          root_ok;
    assign rem_sh  = {r_rem, r_acc[2*SB-1 -: 2]};
    assign trial   = (SB+4)'({r_root, 2'b01});
    assign root_ok = (rem_sh >= trial);

    // saturating band sum
    logic [SW-1:0] sum_ext;
    assign sum_ext = SW'(r_sum) + SW'(r_root);

    // speech decision against floor plus margin, kept at 25 bits
    logic [EW:0] thresh;
    logic        speech;
    assign thresh = {1'b0, rnd_sat} + {1'b0, r_margin};
    assign speech = ({1'b0, r_smooth} >= thresh);

    logic out_free;
    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (in_band)
                        n_state = ST_SQ_A;
                    else if (s_axis_tlast)
                        n_state = ST_SM_A;
                end
            end
            ST_SQ_A:   n_state = ST_SQ_B;
            ST_SQ_B:   n_state = ST_ROOT;
            ST_ROOT:   n_state = (r_cnt == '0) ? ST_ACC : ST_ROOT;
            ST_ACC:    n_state = r_last ? ST_SM_A : ST_IDLE;
            ST_SM_A:   n_state = ST_SM_B;
            ST_SM_B:   n_state = ST_SM_RND;
            ST_SM_RND: n_state = ST_FL_A;
            ST_FL_A:   n_state = ST_FL_B;
            ST_FL_B:   n_state = ST_FL_RND;
            ST_FL_RND: n_state = ST_EMIT;
            ST_EMIT:   n_state = out_free ? ST_IDLE : ST_EMIT;
            default:   n_state = ST_IDLE;
        endcase
    end

    // config write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_start  <= 8'd8;
            r_band_end    <= 8'd26;
            r_fast_keep   <= 15'd24576;
            r_fast_gain   <= 15'd8192;
            r_slow_keep   <= 15'd32440;
            r_slow_gain   <= 15'd328;
            r_margin      <= '0;
            r_hang_frames <= 8'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                evnf_pkg::CFG_BAND_START: r_band_start  <= i_cfg_data[7:0];
                evnf_pkg::CFG_BAND_END:   r_band_end    <= i_cfg_data[7:0];
                evnf_pkg::CFG_FAST_KEEP:  r_fast_keep   <= i_cfg_data[CWC-1:0];
                evnf_pkg::CFG_FAST_GAIN:  r_fast_gain   <= i_cfg_data[CWC-1:0];
                evnf_pkg::CFG_SLOW_KEEP:  r_slow_keep   <= i_cfg_data[CWC-1:0];
                evnf_pkg::CFG_SLOW_GAIN:  r_slow_gain   <= i_cfg_data[CWC-1:0];
                evnf_pkg::CFG_MARGIN:     r_margin      <= i_cfg_data[EW-1:0];
                evnf_pkg::CFG_HANGOVER:   r_hang_frames <= i_cfg_data[7:0];
            endcase
        end
    end

    // sequencer and tracked state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_last      <= 1'b0;
            r_slow      <= 1'b0;
            r_hold      <= '0;
            r_act       <= 1'b0;
            r_sum       <= '0;
            r_smooth    <= '0;
            r_floor     <= '0;
            r_en        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // hand-off loads a new word, otherwise a taken word clears the flag
            if (r_state == ST_EMIT && out_free)
                r_out_valid <= 1'b1;
            else if (m_axis_tready)
                r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc)
                        r_last <= s_axis_tlast;
                end
                ST_SQ_B: r_cnt <= CNW'(SAMPLE_BITS - 1);
                ST_ROOT: r_cnt <= r_cnt - CNW'(1);
                ST_ACC: begin
                    r_sum <= (sum_ext > SW'(evnf_pkg::MAX24)) ? evnf_pkg::MAX24
                                                              : sum_ext[EW-1:0];
                end
                ST_SM_A: begin
                    // frame closes: latch its energy and restart the sum
                    r_en  <= r_sum;
                    r_sum <= '0;
                end
                ST_SM_RND: begin
                    r_smooth <= rnd_sat;
                    r_slow   <= (r_floor < rnd_sat);
                end
                ST_FL_RND: begin
                    r_floor <= rnd_sat;
                    if (speech) begin
                        r_hold <= r_hang_frames;
                        r_act  <= 1'b1;
                    end else if (r_hold != '0) begin
                        r_hold <= r_hold - 8'd1;
                        r_act  <= 1'b1;
                    end else begin
                        r_act  <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath payload, no reset needed
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_mag_a <= mag_re;
                    r_mag_b <= mag_im;
                end
            end
            ST_SQ_A: r_acc <= prod;
            ST_SQ_B: begin
                r_acc  <= r_acc + prod;
                r_rem  <= '0;
                r_root <= '0;
            end
            ST_ROOT: begin
                r_acc  <= r_acc << 2;
                r_root <= {r_root[SB-2:0], root_ok};
                r_rem  <= root_ok ? (SB+2)'(rem_sh - trial) : rem_sh[SB+1:0];
            end
            ST_SM_A: r_acc <= prod;
            ST_SM_B: r_acc <= r_acc + prod;
            ST_FL_A: r_acc <= prod;
            ST_FL_B: r_acc <= r_acc + prod;
            ST_EMIT: begin
                if (out_free) begin
                    r_o_voice  <= r_act;
                    r_o_energy <= r_en;
                    r_o_smooth <= r_smooth;
                    r_o_floor  <= r_floor;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_o_floor, r_o_smooth, r_o_energy, r_o_voice};

endmodule

/* design/evnf_checker.sv */
// port-level checks for the energy vad with noise floor
// depends on evnf_pkg; bound to energy_vad_noise_floor below
module evnf_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             s_axis_tlast,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [evnf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // a result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result word dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // a frame end always leads to the floor update, so input must close
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still open after a frame end");

    // a new result only comes out of the hand-off cycle, when input is closed
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !$past(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a frame update");

endmodule

bind energy_vad_noise_floor evnf_checker u_evnf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
